@@ sv/lbht_pkg.sv @@
// lbht_pkg: shared types and constants for the letterbox action bar hit test
// holds the configuration register codes, sequencer states and fixed widths
// no dependencies
package lbht_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_TARGET_WIDTH  = 3'd2,
        CFG_TARGET_HEIGHT = 3'd3,
        CFG_BUTTON_COUNT  = 3'd4
    } t_cfg_index;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DIM_W      = 16;
    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 3;
    // source coordinates up to twice a 16 bit parameter
    localparam int SRC_W      = 17;
    // source coordinate times a draw size
    localparam int THR_W      = SRC_W + DIM_W;
    localparam int NUM_W      = 2 * DIM_W;
    localparam int DCNT_W     = 5;

    // derived setup sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_H,
        ST_FIT_H,
        ST_DIV_W,
        ST_GOT_W,
        ST_ORIGIN,
        ST_DIV_BTN,
        ST_GOT_BTN,
        ST_LANE_LO,
        ST_LANE_HI,
        ST_Y_LO,
        ST_Y_HI
    } t_state;

endpackage

@@ sv/letterbox_hit_test_action_bar_unit.sv @@
// letterbox_hit_test_action_bar_unit: maps a window pointer back into a letterboxed
// source image and tests it against a row of equal action buttons
// depends on lbht_pkg
//
// One beat in, one beat out. The pointer path is a four stage pipeline (capture,
// origin subtract and margin test, scale multiply, threshold compare) that takes
// a new beat every cycle while o_stall is low. After any configuration write
// the block recomputes the fitted size, origin, button width and per-button
// thresholds with one shared restoring divider, and o_stall stays high while
// it does so. Invalid settings, negative pointers, margins, gaps and bar misses
// give no hit.
module letterbox_hit_test_action_bar_unit #(
    parameter int BAR_X       = 16,
    parameter int BAR_Y       = 400,
    parameter int BAR_WIDTH   = 608,
    parameter int BAR_HEIGHT  = 48,
    parameter int BUTTON_GAP  = 8,
    parameter int MAX_BUTTONS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lbht_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lbht_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [15:0]                 i_pointer_x,
    input  logic signed [15:0]                 i_pointer_y,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_hit,
    output logic [lbht_pkg::INDEX_W-1:0]       o_button_index
);
    import lbht_pkg::*;

    localparam int LANE_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;

    // configuration registers
    logic [DIM_W-1:0]   r_sw, r_sh, r_tw, r_th;
    logic [COUNT_W-1:0] r_n;

    // derived values
    t_state             r_state, n_state;
    logic               r_cfg_ok;
    logic [DIM_W-1:0]   r_dw, r_dh, r_x0, r_y0, r_w;
    logic [SRC_W-1:0]   r_stride, r_lo;
    logic [LANE_W-1:0]  r_lane;
    logic [THR_W-1:0]   r_lo_thr [MAX_BUTTONS];
    logic [THR_W-1:0]   r_hi_thr [MAX_BUTTONS];
    logic [THR_W-1:0]   r_y_lo_thr, r_y_hi_thr;

    // shared divider
    logic [NUM_W-1:0]   r_num, r_quo;
    logic [DIM_W-1:0]   r_den, r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [DIM_W:0]     rem_sh;
    logic               rem_ge;
    logic [DIM_W:0]     rem_sub;
    logic               div_done;

    logic               busy;
    logic [11:0]        total_gap;
    logic [6:0]         lane_last;

    assign rem_sh   = {r_rem, r_num[NUM_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_den};
    assign rem_sub  = rem_sh - {1'b0, r_den};
    assign div_done = (r_dcnt == '1);
    assign busy     = (r_state != ST_IDLE);
    assign total_gap = 12'(8'(BUTTON_GAP) * 12'(r_n - 4'd1));
    assign lane_last = 7'(r_n) - 7'd1;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw <= '0;
            r_sh <= '0;
            r_tw <= '0;
            r_th <= '0;
            r_n  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SOURCE_WIDTH:  r_sw <= i_cfg_data;
                CFG_SOURCE_HEIGHT: r_sh <= i_cfg_data;
                CFG_TARGET_WIDTH:  r_tw <= i_cfg_data;
                CFG_TARGET_HEIGHT: r_th <= i_cfg_data;
                CFG_BUTTON_COUNT:  r_n  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // setup sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  n_state = ST_IDLE;
            ST_CHECK: begin
                if (r_sw == '0 || r_sh == '0 || r_tw == '0 || r_th == '0 ||
                    r_n == '0 || 32'(r_n) > MAX_BUTTONS) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DIV_H;
                end
            end
            ST_DIV_H:   n_state = div_done ? ST_FIT_H : ST_DIV_H;
            ST_FIT_H: begin
                if (r_quo > NUM_W'(r_th)) begin
                    n_state = ST_DIV_W;
                end else begin
                    n_state = ST_ORIGIN;
                end
            end
            ST_DIV_W:   n_state = div_done ? ST_GOT_W : ST_DIV_W;
            ST_GOT_W:   n_state = ST_ORIGIN;
            ST_ORIGIN: begin
                if (r_dw == '0 || r_dh == '0 || 17'(total_gap) >= 17'(BAR_WIDTH)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_DIV_BTN;
                end
            end
            ST_DIV_BTN: n_state = div_done ? ST_GOT_BTN : ST_DIV_BTN;
            ST_GOT_BTN: n_state = (r_quo == '0) ? ST_IDLE : ST_LANE_LO;
            ST_LANE_LO: n_state = ST_LANE_HI;
            ST_LANE_HI: n_state = (7'(r_lane) == lane_last) ? ST_Y_LO : ST_LANE_LO;
            ST_Y_LO:    n_state = ST_Y_HI;
            ST_Y_HI:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
        // any write restarts the setup
        if (i_cfg_we) begin
            n_state = ST_CHECK;
        end
    end

    // setup datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_ok <= 1'b0;
        end else if (i_cfg_we) begin
            r_cfg_ok <= 1'b0;
        end else if (r_state == ST_Y_HI) begin
            r_cfg_ok <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_CHECK: begin
                r_num  <= r_tw * r_sh;
                r_den  <= r_sw;
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            ST_DIV_H, ST_DIV_W, ST_DIV_BTN: begin
                r_rem  <= rem_ge ? rem_sub[DIM_W-1:0] : rem_sh[DIM_W-1:0];
                r_quo  <= {r_quo[NUM_W-2:0], rem_ge};
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_FIT_H: begin
                if (r_quo > NUM_W'(r_th)) begin
                    r_dh   <= r_th;
                    r_num  <= r_th * r_sw;
                    r_den  <= r_sh;
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end else begin
                    r_dh <= r_quo[DIM_W-1:0];
                    r_dw <= r_tw;
                end
            end
            ST_GOT_W: r_dw <= r_quo[DIM_W-1:0];
            ST_ORIGIN: begin
                r_x0   <= (r_tw - r_dw) >> 1;
                r_y0   <= (r_th - r_dh) >> 1;
                r_num  <= NUM_W'(17'(BAR_WIDTH) - 17'(total_gap));
                r_den  <= DIM_W'(r_n);
                r_rem  <= '0;
                r_dcnt <= '0;
            end
            ST_GOT_BTN: begin
                r_w      <= r_quo[DIM_W-1:0];
                r_stride <= SRC_W'(r_quo[DIM_W-1:0]) + SRC_W'(BUTTON_GAP);
                r_lo     <= SRC_W'(BAR_X);
                r_lane   <= '0;
            end
            ST_LANE_LO: r_lo_thr[r_lane] <= r_lo * r_dw;
            ST_LANE_HI: begin
                r_hi_thr[r_lane] <= (r_lo + SRC_W'(r_w)) * r_dw;
                r_lo             <= r_lo + r_stride;
                r_lane           <= r_lane + 1'b1;
            end
            ST_Y_LO: r_y_lo_thr <= SRC_W'(BAR_Y) * r_dh;
            ST_Y_HI: r_y_hi_thr <= (SRC_W'(BAR_Y) + SRC_W'(BAR_HEIGHT)) * r_dh;
            default: ;
        endcase
    end

    // pointer pipeline, each stage holds only while the next one is full and held
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    assign en4 = !r_v4 || !i_stall;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_stall = busy || !en1;

    // stage 1: capture
    logic             r_neg1;
    logic [14:0]      r_px1, r_py1;
    // stage 2: origin subtract and margin test
    logic             r_ok2;
    logic [DIM_W-1:0] r_dx2, r_dy2;
    // stage 3: scale to source units
    logic             r_ok3;
    logic [NUM_W-1:0] r_p3, r_q3;
    // stage 4: result
    logic             r_hit4;
    logic [INDEX_W-1:0] r_idx4;

    logic             in_x, in_y;
    logic [MAX_BUTTONS-1:0] lane_match;
    logic [LANE_W-1:0] lane_idx;
    logic             y_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid && !busy;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    assign in_x = ({2'b0, r_px1} >= {1'b0, r_x0}) &&
                  ({2'b0, r_px1} < ({1'b0, r_x0} + {1'b0, r_dw}));
    assign in_y = ({2'b0, r_py1} >= {1'b0, r_y0}) &&
                  ({2'b0, r_py1} < ({1'b0, r_y0} + {1'b0, r_dh}));

    always_comb begin
        lane_idx = '0;
        for (int i = 0; i < MAX_BUTTONS; i++) begin
            lane_match[i] = (7'(i) < 7'(r_n)) &&
                            (THR_W'(r_p3) >= r_lo_thr[i]) &&
                            (THR_W'(r_p3) < r_hi_thr[i]);
            if (lane_match[i]) begin
                lane_idx = lane_idx | LANE_W'(i);
            end
        end
    end

    assign y_match = (THR_W'(r_q3) >= r_y_lo_thr) && (THR_W'(r_q3) < r_y_hi_thr);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_neg1 <= i_pointer_x[15] || i_pointer_y[15];
            r_px1  <= i_pointer_x[14:0];
            r_py1  <= i_pointer_y[14:0];
        end
        if (en2) begin
            r_ok2 <= !r_neg1 && r_cfg_ok && in_x && in_y;
            r_dx2 <= DIM_W'(r_px1) - r_x0;
            r_dy2 <= DIM_W'(r_py1) - r_y0;
        end
        if (en3) begin
            r_ok3 <= r_ok2;
            r_p3  <= r_dx2 * r_sw;
            r_q3  <= r_dy2 * r_sh;
        end
        if (en4) begin
            r_hit4 <= r_ok3 && y_match && (|lane_match);
            r_idx4 <= (r_ok3 && y_match && (|lane_match)) ?
                      INDEX_W'(7'(lane_idx)) : '0;
        end
    end

    assign o_valid        = r_v4;
    assign o_hit          = r_hit4;
    assign o_button_index = r_idx4;

endmodule

@@ test/letterbox_hit_test_action_bar_unit_test.sv @@
// letterbox_hit_test_action_bar_unit_test: checks pointer hit results against an
// in-bench model of the letterbox mapping and button split, under random idling
// depends on lbht_pkg and letterbox_hit_test_action_bar_unit
`timescale 1ns / 1ps

module letterbox_hit_test_action_bar_unit_test;
    import lbht_pkg::*;

    localparam int BAR_X = 16, BAR_Y = 400, BAR_WIDTH = 608, BAR_HEIGHT = 48;
    localparam int BUTTON_GAP = 8, MAX_BUTTONS = 8;

    typedef struct packed {
        logic       hit;
        logic [2:0] index;
    } t_hit_result;

    logic i_clk = 1'b0, i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0, i_stall = 1'b0;
    logic signed [15:0] i_pointer_x = '0, i_pointer_y = '0;
    logic o_stall, o_valid, o_hit;
    logic [INDEX_W-1:0] o_button_index;

    logic [15:0] src_w, src_h, tgt_w, tgt_h;
    logic [3:0]  btn_n;
    t_hit_result hits_due[$];
    int  fails = 0;
    bit  rx_idle_on = 1'b1, hold_rx = 1'b0, tx_idle_on = 1'b1;
    int  hold_cycles = 0;

    letterbox_hit_test_action_bar_unit DUT (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400ms;
        $display("TEST FAILED");
        $finish;
    end

    function automatic t_hit_result locate_button(logic [15:0] px_raw, logic [15:0] py_raw);
        longint unsigned sw, sh, tw, th, n, dw, dh, x0, y0, px, py, sx, sy;
        longint unsigned tg, w, lx, stride, cand;
        t_hit_result r;
        r = '0;
        sw = src_w; sh = src_h; tw = tgt_w; th = tgt_h; n = btn_n;
        if (sw == 0 || sh == 0 || tw == 0 || th == 0 || n == 0 || n > MAX_BUTTONS)
            return r;
        if (px_raw[15] || py_raw[15]) return r;
        px = px_raw[14:0];
        py = py_raw[14:0];
        dw = tw;
        dh = dw * sh / sw;
        if (dh > th) begin
            dh = th;
            dw = dh * sw / sh;
        end
        if (dw == 0 || dh == 0) return r;
        x0 = (tw - dw) / 2;
        y0 = (th - dh) / 2;
        if (px < x0 || py < y0 || px >= x0 + dw || py >= y0 + dh) return r;
        sx = (px - x0) * sw / dw;
        sy = (py - y0) * sh / dh;
        if (sx < BAR_X || sx >= BAR_X + BAR_WIDTH || sy < BAR_Y || sy >= BAR_Y + BAR_HEIGHT)
            return r;
        tg = BUTTON_GAP * (n - 1);
        if (tg >= BAR_WIDTH) return r;
        w = (BAR_WIDTH - tg) / n;
        if (w == 0) return r;
        lx = sx - BAR_X;
        stride = w + BUTTON_GAP;
        cand = lx / stride;
        if (cand >= n || lx % stride >= w) return r;
        r.hit = 1'b1;
        r.index = cand[2:0];
        return r;
    endfunction

    // receiver: random stall bursts, or a long counted hold
    initial begin
        int burst;
        forever begin
            @(posedge i_clk);
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (hold_cycles) @(posedge i_clk);
                hold_rx = 1'b0;
                i_stall <= 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (burst - 1) @(posedge i_clk);
                @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_hit_result due;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hits_due.size() == 0) begin
                $display("%0t: unexpected result hit=%0b index=%0d", $time, o_hit,
                         o_button_index);
                fails++;
            end else begin
                due = hits_due.pop_front();
                if (o_hit !== due.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, due.hit, o_hit);
                    fails++;
                end
                if (o_button_index !== due.index) begin
                    $display("%0t: button_index expected %0d actual %0d", $time,
                             due.index, o_button_index);
                    fails++;
                end
            end
        end
    end

    // valid stays high after a beat so that beats can follow back to back
    task automatic send_pointer(logic [15:0] x, logic [15:0] y);
        if (tx_idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pointer_x <= x;
        i_pointer_y <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        hits_due.push_back(locate_button(x, y));
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (hits_due.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SOURCE_WIDTH:  src_w = val;
            CFG_SOURCE_HEIGHT: src_h = val;
            CFG_TARGET_WIDTH:  tgt_w = val;
            CFG_TARGET_HEIGHT: tgt_h = val;
            default:           btn_n = val[3:0];
        endcase
    endtask

    task automatic set_view(logic [15:0] sw, logic [15:0] sh, logic [15:0] tw,
                            logic [15:0] th, logic [3:0] n);
        drain();
        write_reg(CFG_SOURCE_WIDTH, sw);
        write_reg(CFG_SOURCE_HEIGHT, sh);
        write_reg(CFG_TARGET_WIDTH, tw);
        write_reg(CFG_TARGET_HEIGHT, th);
        write_reg(CFG_BUTTON_COUNT, {12'd0, n});
        i_cfg_we <= 1'b0;
    endtask

    // pointer aimed at the bar of the current view, or anywhere
    task automatic send_aimed;
        longint unsigned dw, dh, sx, sy;
        logic [15:0] x, y;
        if ($urandom_range(0, 9) < 8 && src_w != 0 && src_h != 0 && tgt_w != 0) begin
            dw = tgt_w;
            dh = dw * src_h / src_w;
            if (dh > tgt_h) begin
                dh = tgt_h;
                dw = dh * src_w / src_h;
            end
            sx = $urandom_range(BAR_X - 4, BAR_X + BAR_WIDTH + 4);
            sy = $urandom_range(BAR_Y - 4, BAR_Y + BAR_HEIGHT + 4);
            x = 16'((tgt_w - dw) / 2 + sx * dw / src_w + $urandom_range(0, 1));
            y = 16'((tgt_h - dh) / 2 + sy * dh / src_h + $urandom_range(0, 1));
            x[15] = ($urandom_range(0, 30) == 0);
            y[15] = ($urandom_range(0, 30) == 0);
        end else begin
            x = 16'($urandom);
            y = 16'($urandom);
        end
        send_pointer(x, y);
    endtask

    task automatic test_reset_invalid;
        send_pointer(16'd100, 16'd420);
        send_pointer(16'h7fff, 16'h7fff);
    endtask

    task automatic test_directed;
        set_view(16'd640, 16'd480, 16'd640, 16'd480, 4'd4);
        send_pointer(16'd20, 16'd410);
        send_pointer(16'd170, 16'd410);
        send_pointer(16'd600, 16'd440);
        send_pointer(16'd10, 16'd410);
        send_pointer(16'd100, 16'd399);
        send_pointer(16'h8000, 16'd410);
        send_pointer(16'd100, 16'hffff);
        send_pointer(16'h7fff, 16'h7fff);
        send_pointer(16'd0, 16'd0);
        // letterbox margin: tall window
        set_view(16'd640, 16'd480, 16'd640, 16'd960, 4'd8);
        send_pointer(16'd100, 16'd10);
        send_pointer(16'd100, 16'd900);
        send_pointer(16'd100, 16'd640);
        // zero draw size
        set_view(16'd65535, 16'd1, 16'd100, 16'd100, 4'd1);
        send_pointer(16'd50, 16'd50);
        // too many buttons, then zero buttons
        set_view(16'd640, 16'd480, 16'd640, 16'd480, 4'd9);
        send_pointer(16'd20, 16'd410);
        set_view(16'd640, 16'd480, 16'd640, 16'd480, 4'd15);
        send_pointer(16'd20, 16'd410);
        set_view(16'd640, 16'd480, 16'd640, 16'd480, 4'd0);
        send_pointer(16'd20, 16'd410);
        set_view(16'd65535, 16'd65535, 16'd65535, 16'd65535, 4'd8);
        send_pointer(16'd600, 16'd410);
        send_pointer(16'h7fff, 16'h7fff);
    endtask

    task automatic test_random(int count);
        int k;
        for (k = 0; k < count; k++) begin
            if (k % 60 == 0) begin
                case ($urandom_range(0, 4))
                    0: set_view(16'($urandom), 16'($urandom), 16'($urandom),
                                16'($urandom), 4'($urandom));
                    1: set_view(16'd640, 16'd480, 16'($urandom_range(300, 4000)),
                                16'($urandom_range(300, 4000)), 4'($urandom_range(1, 8)));
                    2: set_view(16'($urandom_range(640, 2000)),
                                16'($urandom_range(460, 2000)),
                                16'($urandom_range(1, 65535)),
                                16'($urandom_range(1, 65535)), 4'($urandom_range(1, 8)));
                    3: set_view(16'd65535, 16'd65535, 16'($urandom_range(1, 32767)),
                                16'($urandom_range(1, 32767)), 4'($urandom_range(0, 9)));
                    default: set_view(16'd640, 16'd480, 16'd1280, 16'd960,
                                      4'($urandom_range(1, 8)));
                endcase
            end
            send_aimed();
        end
    endtask

    task automatic test_backpressure;
        int k;
        set_view(16'd640, 16'd480, 16'd640, 16'd480, 4'd8);
        hold_cycles = 200;
        hold_rx = 1'b1;
        for (k = 0; k < 60; k++) send_aimed();
    endtask

    initial begin
        src_w = 0; src_h = 0; tgt_w = 0; tgt_h = 0; btn_n = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_invalid();
        test_directed();
        test_backpressure();
        test_random(1500);
        rx_idle_on = 1'b0;
        tx_idle_on = 1'b0;
        test_random(200);
        drain();
        if (hits_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, hits_due.size());
            fails++;
        end
        if (fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
